/* rtl/rmts_pkg.sv */
package rmts_pkg;

    // Task slots built into the register map
    localparam int MAX_TASKS = 4;
    localparam int TASK_IW = 2;

    localparam int TIME_W = 16;
    localparam logic [3:0] BACKLOG_MAX = 4'd15;

    // Configuration register map
    localparam int CFG_IW = 4;
    localparam logic [CFG_IW-1:0] CFG_PERIOD_BASE = 4'd0;
    localparam logic [CFG_IW-1:0] CFG_EXEC_BASE = 4'd4;
    localparam logic [CFG_IW-1:0] CFG_REG_COUNT = 4'd8;

    typedef enum logic [2:0] {
        KIND_IDLE      = 3'd0,
        KIND_PERIODIC  = 3'd1,
        KIND_APERIODIC = 3'd2,
        KIND_ACCEPT    = 3'd3,
        KIND_DROP      = 3'd4
    } kind_t;

    typedef logic [MAX_TASKS-1:0][TIME_W-1:0] task_word_t;

    // Outcome of the periodic part of one tick
    typedef struct packed {
        logic               found;
        logic [TASK_IW-1:0] id;
        logic [TIME_W-1:0]  rem;
        logic               done;
        logic               lost;
    } per_result_t;

    // A zero execution time counts as one tick
    function automatic logic [TIME_W-1:0] eff_exec(input logic [TIME_W-1:0] e);
        return (e == '0) ? TIME_W'(1) : e;
    endfunction

endpackage

/* rtl/rmts_periodic.sv */
module rmts_periodic
    import rmts_pkg::*;
#(
    parameter int NUM_TASKS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  task_word_t  period,
    input  task_word_t  exec_time,
    input  logic        tick_go,
    output per_result_t pres
);

    logic [TIME_W-1:0] cd_reg   [MAX_TASKS];
    logic [TIME_W-1:0] hr_reg   [MAX_TASKS];
    logic [3:0]        bl_reg   [MAX_TASKS];
    logic [TIME_W-1:0] cd_next  [MAX_TASKS];
    logic [TIME_W-1:0] hr_next  [MAX_TASKS];
    logic [3:0]        bl_next  [MAX_TASKS];

    logic               lost;
    logic               found;
    logic [TASK_IW-1:0] best;
    logic [16:0]        best_key;
    logic [16:0]        key;
    logic [TIME_W-1:0]  hr_dec;
    logic [3:0]         bl_dec;

    // Release, pick the shortest period, run the winner for one tick
    always_comb begin
        for (int t = 0; t < MAX_TASKS; t++) begin
            cd_next[t] = cd_reg[t];
            hr_next[t] = hr_reg[t];
            bl_next[t] = bl_reg[t];
        end
        lost = 1'b0;

        for (int t = 0; t < MAX_TASKS; t++) begin
            if (t < NUM_TASKS) begin
                if (period[t] == '0) begin
                    cd_next[t] = '0;
                end else if (cd_reg[t] == '0) begin
                    if (bl_reg[t] == '0) begin
                        hr_next[t] = eff_exec(exec_time[t]);
                        bl_next[t] = 4'd1;
                    end else if (bl_reg[t] < BACKLOG_MAX) begin
                        bl_next[t] = bl_reg[t] + 4'd1;
                    end else begin
                        lost = 1'b1;
                    end
                    cd_next[t] = period[t] - TIME_W'(1);
                end else begin
                    cd_next[t] = cd_reg[t] - TIME_W'(1);
                end
            end
        end

        found    = 1'b0;
        best     = '0;
        best_key = '0;
        key      = '0;
        for (int t = 0; t < MAX_TASKS; t++) begin
            if (t < NUM_TASKS && bl_next[t] != '0) begin
                // disabled tasks rank below every enabled one
                key = (period[t] == '0) ? 17'h10000 : {1'b0, period[t]};
                if (!found || key < best_key) begin
                    found    = 1'b1;
                    best     = TASK_IW'(t);
                    best_key = key;
                end
            end
        end

        hr_dec = (hr_next[best] != '0) ? hr_next[best] - TIME_W'(1) : '0;
        bl_dec = bl_next[best] - 4'd1;
        if (found) begin
            hr_next[best] = hr_dec;
            if (hr_dec == '0) begin
                bl_next[best] = bl_dec;
                if (bl_dec != '0) begin
                    hr_next[best] = eff_exec(exec_time[best]);
                end
            end
        end

        pres.found = found;
        pres.id    = best;
        pres.rem   = hr_dec;
        pres.done  = found && (hr_dec == '0);
        pres.lost  = lost;
    end

    // Commit task state on each tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < MAX_TASKS; t++) begin
                cd_reg[t] <= '0;
                hr_reg[t] <= '0;
                bl_reg[t] <= '0;
            end
        end else if (tick_go) begin
            for (int t = 0; t < MAX_TASKS; t++) begin
                cd_reg[t] <= cd_next[t];
                hr_reg[t] <= hr_next[t];
                bl_reg[t] <= bl_next[t];
            end
        end
    end

endmodule

/* rtl/rate_monotonic_tick_scheduler.sv */
// Channel   Direction  Handshake                 Payload
// s_axis    in         s_axis_tvalid/tready      tuser: op; tdata: ap_id, ap_execution
// m_axis    out        m_axis_tvalid/tready      tuser: kind; tdata: task_id .. tick_time
// cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// An arrival, or a tick served by a periodic task (or idle), is answered from ST_IDLE.
// A tick that falls to the aperiodic queue passes through ST_APREAD: the head entry
// comes out of the queue memory in the cycle after the request is taken.
// Reset (aresetn low, synchronous) empties the queue and clears all task state;
// no clearing pass is needed. A stalled result holds the input off until taken.
module rate_monotonic_tick_scheduler
    import rmts_pkg::*;
#(
    parameter int NUM_TASKS = 4,
    parameter int AP_DEPTH  = 16
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [23:0]         s_axis_tdata,  // [7:0] ap_id, [23:8] ap_execution
    input  logic                s_axis_tuser,  // [0] op

    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [63:0]         m_axis_tdata,  // [7:0] task_id, [23:8] remaining_after,
                                               // [24] job_done, [25] release_lost,
                                               // [57:26] tick_time
    output logic [2:0]          m_axis_tuser,  // [2:0] kind

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [TIME_W-1:0]   cfg_data
);

    localparam int AW = (AP_DEPTH > 1) ? $clog2(AP_DEPTH) : 1;
    localparam int CW = $clog2(AP_DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_APREAD
    } state_t;

    state_t             state_reg;
    logic               m_valid_reg;
    kind_t              kind_reg;
    logic [7:0]         id_reg;
    logic [TIME_W-1:0]  rem_reg;
    logic               done_reg;
    logic               lost_reg;
    logic [31:0]        time_reg;

    logic [31:0]        tick_reg;
    logic [31:0]        pend_time_reg;
    logic               pend_lost_reg;
    logic [AW-1:0]      head_reg;
    logic [CW-1:0]      count_reg;

    task_word_t         period_reg;
    task_word_t         exec_reg;

    logic [23:0]        apq_mem [AP_DEPTH];
    logic [23:0]        rd_data_reg;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [23:0]        wr_data;

    logic               in_ok;
    logic               out_free;
    logic               op;
    logic [7:0]         in_id;
    logic [TIME_W-1:0]  in_ex;
    logic               tick_go;
    logic               q_full;
    logic [AW:0]        tail_sum;
    logic [AW-1:0]      tail;
    logic [AW-1:0]      head_inc;
    logic [TIME_W-1:0]  ap_left;
    per_result_t        pres;

    assign op    = s_axis_tuser;
    assign in_id = s_axis_tdata[7:0];
    assign in_ex = eff_exec(s_axis_tdata[23:8]);

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign in_ok         = s_axis_tvalid && s_axis_tready;
    assign tick_go       = in_ok && !op;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tdata  = {6'b0, time_reg, lost_reg, done_reg, rem_reg, id_reg};

    // Configuration registers: always ready, unknown indexes are ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < MAX_TASKS; t++) begin
                period_reg[t] <= '0;
                exec_reg[t]   <= TIME_W'(1);
            end
        end else if (cfg_valid) begin
            if (cfg_index < CFG_EXEC_BASE) begin
                period_reg[cfg_index[TASK_IW-1:0]] <= cfg_data;
            end else if (cfg_index < CFG_REG_COUNT) begin
                exec_reg[cfg_index[TASK_IW-1:0]] <= cfg_data;
            end
        end
    end

    rmts_periodic #(
        .NUM_TASKS (NUM_TASKS)
    ) u_periodic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .period    (period_reg),
        .exec_time (exec_reg),
        .tick_go   (tick_go),
        .pres      (pres)
    );

    // Queue pointers
    assign q_full   = (count_reg == CW'(AP_DEPTH));
    assign tail_sum = {1'b0, head_reg} + (AW + 1)'(count_reg);
    assign tail     = (tail_sum >= (AW + 1)'(AP_DEPTH))
                      ? AW'(tail_sum - (AW + 1)'(AP_DEPTH)) : tail_sum[AW-1:0];
    assign head_inc = (head_reg == AW'(AP_DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign ap_left  = (rd_data_reg[15:0] != '0) ? rd_data_reg[15:0] - TIME_W'(1) : '0;

    // Single write port: push on arrival, write back the served head
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = head_reg;
        wr_data = {rd_data_reg[23:16], ap_left};
        if (state_reg == ST_APREAD) begin
            wr_en = 1'b1;
        end else if (in_ok && op && !q_full) begin
            wr_en   = 1'b1;
            wr_addr = tail;
            wr_data = {in_id, in_ex};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            apq_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= apq_mem[head_reg];
    end

    // Sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            tick_reg    <= '0;
            head_reg    <= '0;
            count_reg   <= '0;
        end else begin
            if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_ok) begin
                        time_reg <= tick_reg;
                        lost_reg <= 1'b0;
                        done_reg <= 1'b0;
                        if (op) begin
                            // arrival: push or drop
                            m_valid_reg <= 1'b1;
                            id_reg      <= in_id;
                            if (!q_full) begin
                                kind_reg  <= KIND_ACCEPT;
                                rem_reg   <= in_ex;
                                count_reg <= count_reg + CW'(1);
                            end else begin
                                kind_reg <= KIND_DROP;
                                rem_reg  <= '0;
                            end
                        end else begin
                            tick_reg <= tick_reg + 32'd1;
                            lost_reg <= pres.lost;
                            if (pres.found) begin
                                m_valid_reg <= 1'b1;
                                kind_reg    <= KIND_PERIODIC;
                                id_reg      <= {6'b0, pres.id};
                                rem_reg     <= pres.rem;
                                done_reg    <= pres.done;
                            end else if (count_reg != '0) begin
                                // wait for the head entry
                                pend_time_reg <= tick_reg;
                                pend_lost_reg <= pres.lost;
                                state_reg     <= ST_APREAD;
                            end else begin
                                m_valid_reg <= 1'b1;
                                kind_reg    <= KIND_IDLE;
                                id_reg      <= '0;
                                rem_reg     <= '0;
                            end
                        end
                    end
                end
                ST_APREAD: begin
                    m_valid_reg <= 1'b1;
                    kind_reg    <= KIND_APERIODIC;
                    id_reg      <= rd_data_reg[23:16];
                    rem_reg     <= ap_left;
                    done_reg    <= (ap_left == '0);
                    lost_reg    <= pend_lost_reg;
                    time_reg    <= pend_time_reg;
                    if (ap_left == '0) begin
                        head_reg  <= head_inc;
                        count_reg <= count_reg - CW'(1);
                    end
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
